FILE: hw/rtl/rpm_pkg.sv
// Package for the RC pulse to PWM mapper: request and result types, register
// indexes, interval limits and the reciprocal constants of the duty scaler.
// No dependencies.
package rpm_pkg;

    localparam int STAMP_W  = 32;
    localparam int DUTY_W   = 16;
    localparam int NUM_W    = 10;
    localparam int PROD_W   = DUTY_W + NUM_W;
    localparam int DIV_W    = 10;
    localparam int RECIP_SHIFT = PROD_W + DIV_W;
    localparam int RECIP_W  = RECIP_SHIFT - DIV_W + 1;
    localparam int WIDE_W   = PROD_W + RECIP_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD   = 2'd0,
        CFG_RIGHT_ENABLE = 2'd1,
        CFG_LEFT_ENABLE  = 2'd2,
        CFG_AUTO_MODE    = 2'd3
    } cfg_idx_t;

    localparam logic [DUTY_W-1:0] PERIOD_RESET = 16'd1000;

    // interval limits (exclusive bounds)
    localparam logic [STAMP_W-1:0] RIGHT_BASE  = 32'd1750;
    localparam logic [STAMP_W-1:0] RIGHT_LO    = 32'd1810;
    localparam logic [STAMP_W-1:0] RIGHT_HI    = 32'd2450;
    localparam logic [STAMP_W-1:0] LEFT_BASE   = 32'd1730;
    localparam logic [STAMP_W-1:0] LEFT_LO     = 32'd1000;
    localparam logic [STAMP_W-1:0] LEFT_HI     = 32'd1657;
    localparam logic [STAMP_W-1:0] THR_LO      = 32'd1780;
    localparam logic [STAMP_W-1:0] THR_HI      = 32'd2380;
    localparam logic [STAMP_W-1:0] THR_BASE    = 32'd1787;

    localparam longint unsigned RightDiv = 600;
    localparam longint unsigned LeftDiv  = 730;
    localparam longint unsigned ThrDiv   = 570;

    localparam longint unsigned ScaleOne = 64'd1 << RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] RECIP_RIGHT =
        RECIP_W'((ScaleOne + RightDiv - 1) / RightDiv);
    localparam logic [RECIP_W-1:0] RECIP_LEFT =
        RECIP_W'((ScaleOne + LeftDiv - 1) / LeftDiv);
    localparam logic [RECIP_W-1:0] RECIP_THR =
        RECIP_W'((ScaleOne + ThrDiv - 1) / ThrDiv);

    typedef enum logic [1:0] {
        SEL_RIGHT,
        SEL_LEFT,
        SEL_THROTTLE
    } sel_t;

    typedef struct packed {
        logic               channel;
        logic [STAMP_W-1:0] stamp;
    } in_t;

    typedef struct packed {
        logic              write_a;
        logic [DUTY_W-1:0] duty_a;
        logic              write_b;
        logic [DUTY_W-1:0] duty_b;
        logic              write_c;
        logic [DUTY_W-1:0] duty_c;
    } out_t;

    typedef struct packed {
        sel_t             sel;
        logic             zero;
        logic [NUM_W-1:0] num;
    } job_t;

endpackage

FILE: hw/rtl/rpm_interval.sv
// Input register, per-channel stamp store and interval classification.
// Depends on rpm_pkg.
module rpm_interval (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  rpm_pkg::in_t  in_data,
    input  logic          right_enable,
    input  logic          left_enable,
    input  logic          auto_mode,
    output logic          job_valid,
    output rpm_pkg::job_t job
);
    import rpm_pkg::*;

    logic               s0_valid_reg;
    in_t                s0_data_reg;
    logic [STAMP_W-1:0] last_stamp_reg [2];
    logic [1:0]         stamp_valid_reg;
    logic               job_valid_reg;
    job_t               job_reg;

    logic               ch;
    logic [STAMP_W-1:0] d;
    logic               hit_right;
    logic               hit_left;
    logic               hit_thr;
    logic               live;
    logic               job_valid_next;
    job_t               job_next;

    always_comb
    begin
        ch        = s0_data_reg.channel;
        d         = s0_data_reg.stamp - last_stamp_reg[ch];
        live      = s0_valid_reg && !auto_mode;
        hit_right = !ch && d > RIGHT_LO && d < RIGHT_HI && right_enable;
        hit_left  = !ch && d > LEFT_LO && d < LEFT_HI && left_enable;
        hit_thr   = ch && d > THR_LO && d < THR_HI;

        job_next.zero = 1'b0;
        if (ch)
        begin
            job_next.sel  = SEL_THROTTLE;
            job_next.zero = d <= THR_BASE;
            job_next.num  = job_next.zero ? '0 : NUM_W'(d - THR_BASE);
        end
        else if (hit_right)
        begin
            job_next.sel = SEL_RIGHT;
            job_next.num = NUM_W'(d - RIGHT_BASE);
        end
        else
        begin
            job_next.sel = SEL_LEFT;
            job_next.num = NUM_W'(LEFT_BASE - d);
        end

        job_valid_next = live && stamp_valid_reg[ch] && (hit_right || hit_left || hit_thr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg      <= 1'b0;
            job_valid_reg     <= 1'b0;
            stamp_valid_reg   <= '0;
            last_stamp_reg[0] <= '0;
            last_stamp_reg[1] <= '0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= in_valid;
            job_valid_reg <= job_valid_next;
            if (live)
            begin
                stamp_valid_reg[ch] <= 1'b1;
                last_stamp_reg[ch]  <= s0_data_reg.stamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_data_reg <= in_data;
            job_reg     <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

FILE: hw/rtl/rpm_scaler.sv
// Duty scaler: period times offset, reciprocal multiply for the constant
// divide, then saturation and result assembly. Depends on rpm_pkg.
module rpm_scaler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       job_valid,
    input  rpm_pkg::job_t              job,
    input  logic [rpm_pkg::DUTY_W-1:0] period,
    output logic                       res_valid,
    output rpm_pkg::out_t              res
);
    import rpm_pkg::*;

    logic               p_valid_reg;
    sel_t               p_sel_reg;
    logic               p_zero_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [RECIP_W-1:0] recip_reg;

    logic               q_valid_reg;
    sel_t               q_sel_reg;
    logic               q_zero_reg;
    logic [DUTY_W:0]    quot_reg;

    logic [PROD_W-1:0]  prod_next;
    logic [RECIP_W-1:0] recip_next;
    logic [WIDE_W-1:0]  wide;
    logic [DUTY_W-1:0]  duty;

    always_comb
    begin
        prod_next = PROD_W'(period) * PROD_W'(job.num);
        case (job.sel)
            SEL_RIGHT:    recip_next = RECIP_RIGHT;
            SEL_LEFT:     recip_next = RECIP_LEFT;
            SEL_THROTTLE: recip_next = RECIP_THR;
            default:      recip_next = '0;
        endcase
    end

    assign wide = WIDE_W'(prod_reg) * WIDE_W'(recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= job_valid;
            q_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_sel_reg  <= job.sel;
            p_zero_reg <= job.zero;
            prod_reg   <= prod_next;
            recip_reg  <= recip_next;
            q_sel_reg  <= p_sel_reg;
            q_zero_reg <= p_zero_reg;
            quot_reg   <= wide[RECIP_SHIFT +: DUTY_W+1];
        end
    end

    always_comb
    begin
        if (q_zero_reg)
            duty = '0;
        else if (quot_reg >= {1'b0, period})
            duty = period - 16'd1;
        else
            duty = quot_reg[DUTY_W-1:0];

        res = '0;
        case (q_sel_reg)
            SEL_RIGHT:
            begin
                res.write_a = 1'b1;
                res.duty_a  = duty;
                res.write_b = 1'b1;
            end
            SEL_LEFT:
            begin
                res.write_b = 1'b1;
                res.duty_b  = duty;
                res.write_a = 1'b1;
            end
            SEL_THROTTLE:
            begin
                res.write_c = 1'b1;
                res.duty_c  = duty;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    assign res_valid = q_valid_reg;

endmodule

FILE: hw/rtl/rc_pulse_to_pwm_mapper.sv
// Top level of the RC pulse to PWM mapper: configuration registers, output
// register and handshake. Depends on rpm_pkg, rpm_interval and rpm_scaler.
//
// Each request is a receiver edge (channel, 32-bit tick stamp). The block
// measures the interval since the previous edge of that channel and, for a
// steering or throttle pulse width in range, returns one result with the new
// compare values; other edges only record their stamp, if auto mode is off,
// and return nothing. One request is taken every cycle while the output side
// keeps up; a result passes through the input register, interval
// classification, period multiply, reciprocal multiply and output register.
// A result held at the output stalls the whole pipeline. Write the
// configuration registers only while no request is in flight.
module rc_pulse_to_pwm_mapper (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rpm_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rpm_pkg::out_t                  out_data
);
    import rpm_pkg::*;

    logic [DUTY_W-1:0] period_reg;
    logic              right_enable_reg;
    logic              left_enable_reg;
    logic              auto_mode_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;

    logic adv;
    logic job_valid;
    job_t job;
    logic res_valid;
    out_t res;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg       <= PERIOD_RESET;
            right_enable_reg <= 1'b1;
            left_enable_reg  <= 1'b1;
            auto_mode_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PWM_PERIOD:   period_reg       <= cfg_data;
                CFG_RIGHT_ENABLE: right_enable_reg <= cfg_data[0];
                CFG_LEFT_ENABLE:  left_enable_reg  <= cfg_data[0];
                CFG_AUTO_MODE:    auto_mode_reg    <= cfg_data[0];
                default:          period_reg       <= period_reg;
            endcase
        end
    end

    rpm_interval u_interval (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (in_valid),
        .in_data      (in_data),
        .right_enable (right_enable_reg),
        .left_enable  (left_enable_reg),
        .auto_mode    (auto_mode_reg),
        .job_valid    (job_valid),
        .job          (job)
    );

    rpm_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .job_valid (job_valid),
        .job       (job),
        .period    (period_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
